>>> hw/rtl/csa_pkg.sv
package csa_pkg;

	localparam int W       = 32;
	localparam int DEPTH   = 2;
	localparam int LATENCY = W + 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic signed [W-1:0] operand_a;
		logic signed [W-1:0] operand_b;
	} request_t;

	typedef struct packed {
		logic signed [W-1:0] value;
		logic                error;
	} result_t;

	// classified request as it waits in the queue
	typedef struct packed {
		op_t          op;
		logic         neg;
		logic         err;
		logic [W-1:0] val;
		logic [W-1:0] mag_a;
		logic [W-1:0] mag_b;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		op_t            op;
		logic           neg;
		logic           err;
		logic [W-1:0]   val;
		logic [W-1:0]   num;
		logic [W-1:0]   den;
		logic [W:0]     rem;
		logic [2*W-1:0] prod;
	} stage_t;

endpackage

>>> hw/rtl/csa_front.sv
module csa_front (
	input  logic              start,
	input  csa_pkg::request_t request,
	input  csa_pkg::qstat_t   qstat,
	output logic              busy,
	output csa_pkg::push_t    push
);

	logic                  sa;
	logic                  sb;
	logic [csa_pkg::W-1:0] a;
	logic [csa_pkg::W-1:0] b;
	logic [csa_pkg::W-1:0] sum;
	logic [csa_pkg::W-1:0] diff;
	logic                  div_err;

	assign busy = qstat.full;
	assign a    = request.operand_a;
	assign b    = request.operand_b;
	assign sa   = a[csa_pkg::W-1];
	assign sb   = b[csa_pkg::W-1];
	assign sum  = a + b;
	assign diff = a - b;
	assign div_err = (b == '0) ||
		((a == {1'b1, {(csa_pkg::W-1){1'b0}}}) && (b == {csa_pkg::W{1'b1}}));

	always_comb begin
		push.valid       = start && !qstat.full;
		push.entry.op    = request.op;
		push.entry.neg   = sa ^ sb;
		push.entry.mag_a = sa ? (~a + 1'b1) : a;
		push.entry.mag_b = sb ? (~b + 1'b1) : b;
		push.entry.val   = '0;
		push.entry.err   = 1'b0;
		case (request.op)
			csa_pkg::OP_ADD: begin
				push.entry.val = sum;
				push.entry.err = (sa == sb) && (sum[csa_pkg::W-1] != sa);
			end
			csa_pkg::OP_SUB: begin
				push.entry.val = diff;
				push.entry.err = (sa != sb) && (diff[csa_pkg::W-1] != sa);
			end
			csa_pkg::OP_DIV: begin
				push.entry.err = div_err;
			end
			default: begin
				push.entry.err = 1'b0;
			end
		endcase
	end

endmodule

>>> hw/rtl/csa_queue.sv
module csa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  csa_pkg::push_t   push,
	input  logic             pop,
	output csa_pkg::entry_t  head,
	output csa_pkg::qstat_t  qstat
);

	csa_pkg::entry_t mem_q [csa_pkg::DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_pop;

	assign qstat.full  = (count_q == 2'(csa_pkg::DEPTH));
	assign qstat.empty = (count_q == 2'd0);
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push.valid) - 2'(do_pop);
		end
	end

endmodule

>>> hw/rtl/csa_back.sv
module csa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  csa_pkg::entry_t  head,
	input  csa_pkg::qstat_t  qstat,
	output logic             pop,
	output logic             strobe,
	output csa_pkg::result_t result
);

	localparam int W = csa_pkg::W;

	csa_pkg::stage_t pipe_q [W];
	csa_pkg::stage_t nxt    [W];
	logic [W-1:0]    vld_q;
	csa_pkg::stage_t seed;
	csa_pkg::stage_t last;
	logic [W-1:0]    quot;
	logic [W-1:0]    fin_val;

	// one restoring division step per stage
	function automatic csa_pkg::stage_t div_step(input csa_pkg::stage_t s);
		csa_pkg::stage_t r;
		logic [W:0]      rem_sh;
		r      = s;
		rem_sh = {s.rem[W-1:0], s.num[W-1]};
		r.num  = {s.num[W-2:0], 1'b0};
		if (rem_sh >= {1'b0, s.den}) begin
			r.rem    = rem_sh - {1'b0, s.den};
			r.num[0] = 1'b1;
		end else begin
			r.rem = rem_sh;
		end
		return r;
	endfunction

	assign pop = 1'b1;

	always_comb begin
		seed.op   = head.op;
		seed.neg  = head.neg;
		seed.err  = head.err;
		seed.val  = head.val;
		seed.num  = head.mag_a;
		seed.den  = head.mag_b;
		seed.rem  = '0;
		seed.prod = '0;
	end

	always_comb begin
		nxt[0]      = div_step(seed);
		nxt[0].prod = (2*W)'(seed.num) * (2*W)'(seed.den);
		for (int i = 1; i < W; i++) begin
			nxt[i] = div_step(pipe_q[i-1]);
		end
		if (pipe_q[0].op == csa_pkg::OP_MUL) begin
			// magnitude limit is one larger for a negative product
			nxt[1].err = pipe_q[0].prod >
				((2*W)'(1) << (W-1)) - (2*W)'(!pipe_q[0].neg);
			nxt[1].val = pipe_q[0].neg ? (~pipe_q[0].prod[W-1:0] + 1'b1)
				: pipe_q[0].prod[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < W; i++) begin
			pipe_q[i] <= nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			strobe <= 1'b0;
		end else begin
			vld_q  <= {vld_q[W-2:0], !qstat.empty};
			strobe <= vld_q[W-1];
		end
	end

	assign last    = pipe_q[W-1];
	assign quot    = last.neg ? (~last.num + 1'b1) : last.num;
	assign fin_val = (last.op == csa_pkg::OP_DIV) ? quot : last.val;

	always_ff @(posedge clk) begin
		result.error <= last.err;
		result.value <= last.err ? '0 : fin_val;
	end

endmodule

>>> hw/rtl/checked_signed_alu.sv
// Overflow-checked signed ALU: add, subtract, multiply, divide on 32-bit
// two's-complement operands.
// Request channel: drive start with request (op, operand_a, operand_b); the
// request is taken at a rising edge where start is high and busy is low.
// Result channel: strobe is high for one cycle with result (value, error).
// The receiver cannot hold results off; every request gives one result.
// Path to the strobe: the front queue, 32 divider stages, one output register.
// Throughput: one request per cycle while busy is low; all operations share
// the 32-stage restoring-divider pipeline, one quotient bit per stage, so
// order is kept.
// Errors (overflow, divide by zero, minimum over -1) set error and force value
// to zero.
// Reset clears the queue and pipeline valid bits; no result is pending after it.
module checked_signed_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  csa_pkg::request_t request,
	output logic              busy,
	output logic              strobe,
	output csa_pkg::result_t  result
);

	csa_pkg::push_t  push;
	csa_pkg::qstat_t qstat;
	csa_pkg::entry_t head;
	logic            pop;

	csa_front u_front (
		.start   (start),
		.request (request),
		.qstat   (qstat),
		.busy    (busy),
		.push    (push)
	);

	csa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	csa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.strobe (strobe),
		.result (result)
	);

endmodule

>>> hw/rtl/csa_checker.sv
module csa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input csa_pkg::request_t request,
	input logic              busy,
	input logic              strobe,
	input csa_pkg::result_t  result
);

	localparam int LAT = csa_pkg::LATENCY;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.error |-> result.value == '0)
		else $error("error result with non-zero value");

	a_req_gives_res: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT strobe)
		else $error("request without result");

	a_res_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, LAT))
		else $error("result without request");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.op == csa_pkg::OP_DIV && request.operand_b == '0
		|-> ##LAT result.error)
		else $error("divide by zero not flagged");

endmodule

bind checked_signed_alu csa_checker u_chk (.*);

>>> verif/checked_signed_alu_tb.sv
module checked_signed_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = csa_pkg::W;
	localparam logic [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] ALL1  = {W{1'b1}};
	localparam int STALL_LIMIT = 2000;

	class alu_scoreboard;
		csa_pkg::result_t pending[$];
		int               mismatches;

		function csa_pkg::result_t compute(csa_pkg::request_t rq);
			logic [W-1:0]     a, b, ma, mb, r, lim;
			logic [2*W-1:0]   p;
			logic             neg, err;
			csa_pkg::result_t res;
			a = rq.operand_a;
			b = rq.operand_b;
			r = '0;
			err = 1'b0;
			case (rq.op)
				csa_pkg::OP_ADD: begin
					r = a + b;
					err = (a[W-1] == b[W-1]) && (r[W-1] != a[W-1]);
				end
				csa_pkg::OP_SUB: begin
					r = a - b;
					err = (a[W-1] != b[W-1]) && (r[W-1] != a[W-1]);
				end
				csa_pkg::OP_MUL: begin
					neg = a[W-1] ^ b[W-1];
					ma = a[W-1] ? -a : a;
					mb = b[W-1] ? -b : b;
					lim = neg ? S_MIN : S_MAX;
					p = ma * mb;
					if (p > {{W{1'b0}}, lim}) begin
						err = 1'b1;
					end else begin
						r = neg ? -p[W-1:0] : p[W-1:0];
					end
				end
				default: begin
					if (b == '0 || (a == S_MIN && b == ALL1)) begin
						err = 1'b1;
					end else begin
						neg = a[W-1] ^ b[W-1];
						ma = a[W-1] ? -a : a;
						mb = b[W-1] ? -b : b;
						r = ma / mb;
						if (neg) r = -r;
					end
				end
			endcase
			res.value = err ? '0 : r;
			res.error = err;
			return res;
		endfunction

		function void note_request(csa_pkg::request_t rq);
			pending.push_back(compute(rq));
		endfunction

		function void check_result(csa_pkg::result_t got);
			csa_pkg::result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h error=%b", got.value, got.error);
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value || got.error !== want.error) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected value=%h error=%b, got value=%h error=%b",
						want.value, want.error, got.value, got.error);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	csa_pkg::request_t request;
	logic              busy;
	logic              strobe;
	csa_pkg::result_t  result;
	alu_scoreboard     sb;
	int                idle_cycles;

	checked_signed_alu DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .strobe(strobe), .result(result)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_result(result);
		if (arst_n && ((start && !busy) || strobe)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return S_MIN;
			1: return S_MAX;
			2: return ALL1;
			3: return '0;
			4: return W'($urandom_range(0, 16));
			5: return -W'($urandom_range(1, 16));
			6: return W'($signed($urandom_range(0, 131071)) - 65536);
			default: return W'($urandom);
		endcase
	endfunction

	// keep start high across back-to-back requests; drop only on a gap
	task automatic send_request(csa_pkg::op_t op, logic [W-1:0] a, logic [W-1:0] b);
		csa_pkg::request_t rq;
		rq.op = op;
		rq.operand_a = a;
		rq.operand_b = b;
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		sb.note_request(rq);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		logic [W-1:0] edge_vals[6];
		int burst;
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		edge_vals = '{S_MIN, S_MAX, ALL1, '0, W'(1), W'(2)};
		for (int o = 0; o < 4; o++)
			for (int i = 0; i < 6; i += 2)
				send_request(csa_pkg::op_t'(o), edge_vals[i], edge_vals[(i + o + 1) % 6]);
		send_request(csa_pkg::OP_DIV, W'(7), -W'(2));
		send_request(csa_pkg::OP_MUL, W'(65536), -W'(32768));
		send_request(csa_pkg::OP_MUL, W'(65536), W'(32768));
		send_request(csa_pkg::OP_SUB, S_MIN, W'(1));
		send_request(csa_pkg::OP_ADD, S_MAX, S_MAX);
		send_request(csa_pkg::OP_DIV, W'(5), '0);
		pause(3);

		for (int n = 0; n < 1700; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < 1700; k++, n++)
				send_request(csa_pkg::op_t'($urandom_range(0, 3)), rand_operand(),
					rand_operand());
			if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (csa_pkg::LATENCY + 10) @(posedge clk);
		if (sb.mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
